@@ design/flq_pkg.sv @@
`default_nettype none
package flq_pkg;

  // Default sizes of the framer and its frame ring
  localparam int MAX_LEN_DEF     = 64;
  localparam int QUEUE_SLOTS_DEF = 8;

  // Fixed field widths of the channels
  localparam int CHAR_W = 8;
  localparam int CAP_W  = 7;
  localparam int FLEN_W = 6;
  localparam int DROP_W = 16;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SMALL = 2'd2
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    take_byte;
    logic    take_pop;
    logic    fetch;
    logic    load_out;
    logic    step_idx;
    logic    free_slot;
    status_t status;
  } cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic queue_empty;
    logic cap_small;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ design/flq_if.sv @@
`default_nettype none
interface flq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [flq_pkg::CHAR_W-1:0] byte_value;
  logic [flq_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, kind, byte_value, capacity, input ready);
  modport sink (input valid, kind, byte_value, capacity, output ready);
endinterface

interface flq_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [flq_pkg::CHAR_W-1:0] char_value;
  logic [flq_pkg::FLEN_W-1:0] frame_length;
  logic                       last;
  logic [flq_pkg::DROP_W-1:0] drop_count;

  modport source (output valid, status, char_value, frame_length, last, drop_count,
                  input ready);
  modport sink (input valid, status, char_value, frame_length, last, drop_count,
                output ready);
endinterface
`default_nettype wire

@@ design/line_framer_frame_queue.sv @@
// Byte item: gives no result; bytes may follow back to back.
// Pop, empty queue or small destination: result loaded from the check state.
// Pop, success: check, then per character a store read and an output load, each
// load waiting for a free output; next item taken the cycle after the last load.
// Reset (rst, synchronous, active high) empties the ring, clears the partial line,
// the discard flag and the drop count; stored characters are not cleared.
`default_nettype none
module line_framer_frame_queue #(
  parameter int MAX_LEN     = flq_pkg::MAX_LEN_DEF,
  parameter int QUEUE_SLOTS = flq_pkg::QUEUE_SLOTS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  flq_in_if.sink    feed,
  flq_out_if.source result
);
  import flq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_ready;

  // The input side stays ready whenever the sequencer is idle, even while a
  // finished result still waits in the output register: only the load of a
  // new result waits for that register to drain.
  assign feed.ready = ctrl_ready;

  // Sequencer: takes bytes in place, walks a pop through check, store
  // read and output load, one character at a time.
  flq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_kind  (feed.kind),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: line assembly, ring pointers, frame lengths, drop counter,
  // character store and the output register. Characters of the line being
  // assembled go straight into the free slot of the ring, so committing a
  // line only records its length and advances the write slot.
  flq_datapath #(
    .MAX_LEN     (MAX_LEN),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .byte_value (feed.byte_value),
    .capacity   (feed.capacity),
    .result     (result)
  );

endmodule
`default_nettype wire

@@ design/flq_ram.sv @@
`default_nettype none
module flq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/flq_datapath.sv @@
`default_nettype none
module flq_datapath #(
  parameter int MAX_LEN     = flq_pkg::MAX_LEN_DEF,
  parameter int QUEUE_SLOTS = flq_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire flq_pkg::cmd_t              cmd,
  output flq_pkg::stat_t                  stat,
  input  wire logic [flq_pkg::CHAR_W-1:0] byte_value,
  input  wire logic [flq_pkg::CAP_W-1:0]  capacity,
  flq_out_if.source                       result
);
  import flq_pkg::*;

  localparam int LW    = $clog2(MAX_LEN);
  localparam int SW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int AW    = SW + LW;
  localparam int DEPTH = QUEUE_SLOTS << LW;

  localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_LEN - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(QUEUE_SLOTS - 1);

  logic [LW-1:0]     part_len, part_len_next;
  logic              discarding, discarding_next;
  logic [SW-1:0]     wr_slot, wr_slot_next;
  logic [SW-1:0]     rd_slot;
  logic [DROP_W-1:0] drops, drops_next;
  logic [LW-1:0]     lengths [QUEUE_SLOTS];
  logic              commit;
  logic [CAP_W-1:0]  cap_q;
  logic [LW-1:0]     idx;

  logic [SW-1:0]     wr_slot_inc;
  logic [SW-1:0]     rd_slot_inc;
  logic [LW-1:0]     cur_len;
  logic              ram_we;
  logic [CHAR_W-1:0] ram_rdata;

  assign wr_slot_inc = (wr_slot == SLOT_LAST) ? '0 : wr_slot + 1'b1;
  assign rd_slot_inc = (rd_slot == SLOT_LAST) ? '0 : rd_slot + 1'b1;
  assign cur_len     = lengths[rd_slot];

  // Line assembly writes straight into the free slot of the ring
  always_comb begin
    part_len_next   = part_len;
    discarding_next = discarding;
    wr_slot_next    = wr_slot;
    drops_next      = drops;
    commit          = 1'b0;
    ram_we          = 1'b0;
    if (cmd.take_byte) begin
      if (byte_value == CHAR_CR) begin
        // ignore
      end else if (byte_value == CHAR_LF) begin
        part_len_next = '0;
        if (discarding) begin
          discarding_next = 1'b0;
        end else if (part_len != '0) begin
          if (wr_slot_inc == rd_slot) begin
            if (drops != DROP_MAX) drops_next = drops + 1'b1;
          end else begin
            commit       = 1'b1;
            wr_slot_next = wr_slot_inc;
          end
        end
      end else if (!discarding) begin
        if (part_len == LEN_MAX) begin
          discarding_next = 1'b1;
          part_len_next   = '0;
          if (drops != DROP_MAX) drops_next = drops + 1'b1;
        end else begin
          ram_we        = 1'b1;
          part_len_next = part_len + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_len   <= '0;
      discarding <= 1'b0;
      wr_slot    <= '0;
      rd_slot    <= '0;
      drops      <= '0;
    end else begin
      part_len   <= part_len_next;
      discarding <= discarding_next;
      wr_slot    <= wr_slot_next;
      drops      <= drops_next;
      if (cmd.free_slot) rd_slot <= rd_slot_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) lengths[wr_slot] <= part_len;
    if (cmd.take_pop) begin
      cap_q <= capacity;
      idx   <= '0;
    end else if (cmd.step_idx) begin
      idx <= idx + 1'b1;
    end
  end

  flq_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'({wr_slot, part_len})),
    .wdata (byte_value),
    .re    (cmd.fetch),
    .raddr (AW'({rd_slot, idx})),
    .rdata (ram_rdata)
  );

  // Capacities above the limit compare the same as the limit itself
  assign stat.queue_empty = (rd_slot == wr_slot);
  assign stat.cap_small   = (cap_q <= CAP_W'(cur_len)) || (cur_len == '0);
  assign stat.idx_last    = (idx == cur_len - LW'(1));
  assign stat.out_free    = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.status       <= cmd.status;
      result.char_value   <= (cmd.status == ST_OK) ? ram_rdata : '0;
      result.frame_length <= (cmd.status == ST_EMPTY) ? '0 : FLEN_W'(cur_len);
      result.last         <= (cmd.status == ST_OK) ? stat.idx_last : 1'b1;
      result.drop_count   <= drops;
    end
  end

endmodule
`default_nettype wire

@@ design/flq_ctrl.sv @@
`default_nettype none
module flq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_kind,
  output logic                in_ready,
  input  wire flq_pkg::stat_t stat,
  output flq_pkg::cmd_t       cmd
);
  import flq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (kind_t'(in_kind) == KIND_BYTE) begin
            cmd.take_byte = 1'b1;
          end else begin
            cmd.take_pop = 1'b1;
            state_next   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.queue_empty || stat.cap_small) begin
          if (stat.out_free) begin
            cmd.load_out = 1'b1;
            cmd.status   = stat.queue_empty ? ST_EMPTY : ST_SMALL;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.idx_last) begin
            cmd.free_slot = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.step_idx = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule
`default_nettype wire

@@ design/flq_checker.sv @@
`default_nettype none
module flq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       feed_valid,
  input wire logic                       feed_ready,
  input wire logic                       feed_kind,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic [1:0]                 res_status,
  input wire logic [flq_pkg::CHAR_W-1:0] res_char,
  input wire logic [flq_pkg::FLEN_W-1:0] res_len,
  input wire logic                       res_last
);
  import flq_pkg::*;

  // A waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_char) && $stable(res_status))
    else $error("result changed while stalled");

  // Failed pops end their run at once and carry no character
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_EMPTY || res_status == ST_SMALL)
      |-> res_last && res_char == '0)
    else $error("failed pop not a single last item");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_EMPTY |-> res_len == '0)
    else $error("empty status with non-zero length");

  // A byte item never brings forth a result
  assert property (@(posedge clk) disable iff (rst)
    feed_valid && feed_ready && feed_kind == KIND_BYTE && !res_valid |=> !res_valid)
    else $error("result after byte item");

  // No new item is taken while a pop run is still streaming
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_OK && !res_last |-> !feed_ready)
    else $error("item taken during pop run");

endmodule

bind line_framer_frame_queue flq_checker u_flq_checker (
  .clk        (clk),
  .rst        (rst),
  .feed_valid (feed.valid),
  .feed_ready (feed.ready),
  .feed_kind  (feed.kind),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_char   (result.char_value),
  .res_len    (result.frame_length),
  .res_last   (result.last)
);
`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import flq_pkg::*;

  localparam int LINE_MAX    = MAX_LEN_DEF;
  localparam int SLOTS       = QUEUE_SLOTS_DEF;
  localparam int SLOT_W      = $clog2(SLOTS);
  // Generous ceiling. Long pops against a stalling receiver take most of the run.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 40;
  localparam int RAND_ITEMS  = 130;

  // One item on the result channel
  typedef struct packed {
    status_t             status;
    logic [CHAR_W-1:0]   char_value;
    logic [FLEN_W-1:0]   frame_length;
    logic                last;
    logic [DROP_W-1:0]   drop_count;
  } pop_result_t;

  // A result typed in by hand for a directed pop. It stands in for the predicted one.
  typedef struct packed {
    logic                on;
    status_t             st;
    logic [FLEN_W-1:0]   flen;
    logic [DROP_W-1:0]   drops;
  } pin_t;

  // Directed stimulus row.
  // Byte rows send `reps` copies of b, then an optional newline, `lines` times over.
  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   b;
    logic [CAP_W-1:0]    cap;
    logic [6:0]          reps;
    logic                nl;
    logic [3:0]          lines;
    pin_t                pin;
  } dir_row_t;

  localparam pin_t NO_PIN = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  flq_in_if  feed ();
  flq_out_if result ();

  line_framer_frame_queue dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framer mirror: partial line, discard flag, frame ring and drop counter.
  // Everything starts at its post-reset value. Reset is applied only once.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] line_buf   [LINE_MAX];
  logic [CAP_W-1:0]  line_len   = '0;
  logic              skipping   = 1'b0;
  logic [CHAR_W-1:0] ring_chars [SLOTS][LINE_MAX];
  logic [CAP_W-1:0]  ring_len   [SLOTS];
  logic [SLOT_W-1:0] head_slot  = '0;
  logic [SLOT_W-1:0] tail_slot  = '0;
  logic [DROP_W-1:0] drop_total = '0;

  pop_result_t pop_results_due [$];
  pin_t        pins_waiting    [$];

  int items_sent    = 0;
  int pops_sent     = 0;
  int results_seen  = 0;
  int frames_queued = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int burst_left    = 0;

  // Print one line per mismatch, up to a cap, and keep counting past the cap
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] MISMATCH (result %0d): %s", $time, results_seen, msg);
  endtask

  // The drop counter saturates; it never wraps
  task automatic note_drop();
    if (drop_total != DROP_MAX)
      drop_total = drop_total + 1'b1;
  endtask

  // Advance the mirror by one accepted item and queue the results that it causes
  task automatic framer_accept(input kind_t k, input logic [CHAR_W-1:0] b,
                               input logic [CAP_W-1:0] cap, input pin_t pin);
    logic [CAP_W-1:0] room;
    logic [CAP_W-1:0] flen;
    if (k == KIND_BYTE) begin
      if (b == CHAR_LF) begin
        // A newline ends a discard. Otherwise it commits a non-empty line, or drops
        // the line when only the guard slot is left.
        if (skipping) begin
          skipping = 1'b0;
        end else if (line_len != 0) begin
          if (SLOT_W'(tail_slot + 1'b1) == head_slot) begin
            note_drop();
          end else begin
            for (int i = 0; i < line_len; i++)
              ring_chars[tail_slot][i] = line_buf[i];
            ring_len[tail_slot] = line_len;
            tail_slot = tail_slot + 1'b1;
            frames_queued++;
          end
        end
        line_len = '0;
      end else if (b != CHAR_CR && !skipping) begin
        // The first byte past the limit drops the line and starts a discard
        if (line_len >= CAP_W'(LINE_MAX - 1)) begin
          skipping = 1'b1;
          line_len = '0;
          note_drop();
        end else begin
          line_buf[line_len] = b;
          line_len = line_len + 1'b1;
        end
      end
    end else begin
      room = (cap > CAP_W'(LINE_MAX)) ? CAP_W'(LINE_MAX) : cap;
      if (head_slot == tail_slot) begin
        pop_results_due.push_back('{ST_EMPTY, '0, '0, 1'b1, drop_total});
      end else begin
        flen = ring_len[head_slot];
        if (room <= flen || flen == 0) begin
          // Destination too small: the frame stays queued
          pop_results_due.push_back('{ST_SMALL, '0, flen[FLEN_W-1:0], 1'b1, drop_total});
        end else begin
          for (int i = 0; i < flen; i++)
            pop_results_due.push_back('{ST_OK, ring_chars[head_slot][i],
                                        flen[FLEN_W-1:0], (i == flen - 1), drop_total});
          head_slot = head_slot + 1'b1;
        end
      end
      if (pin.on) begin
        void'(pop_results_due.pop_back());
        pop_results_due.push_back('{pin.st, '0, pin.flen, 1'b1, pin.drops});
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Channel monitor: check the result first, then predict from the input item.
  // A result never comes from a pop that is accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pop_result_t want;
    pin_t        pin;
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      if (pop_results_due.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d char %02h",
                                  result.status, result.char_value));
      end else begin
        want = pop_results_due.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, result.status));
        if (result.char_value !== want.char_value)
          report_mismatch($sformatf("char_value: expected %02h, got %02h",
                                    want.char_value, result.char_value));
        if (result.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length: expected %0d, got %0d",
                                    want.frame_length, result.frame_length));
        if (result.last !== want.last)
          report_mismatch($sformatf("last: expected %0b, got %0b", want.last, result.last));
        if (result.drop_count !== want.drop_count)
          report_mismatch($sformatf("drop_count: expected %0d, got %0d",
                                    want.drop_count, result.drop_count));
      end
    end
    if (!rst && feed.valid && feed.ready) begin
      pin = (pins_waiting.size() != 0) ? pins_waiting.pop_front() : NO_PIN;
      framer_accept(kind_t'(feed.kind), feed.byte_value, feed.capacity, pin);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pick a new stall pattern whenever the 6-bit phase counter wraps. The
  // patterns are always ready, coin flip, a short hiccup at one phase of the low three
  // counter bits, and a stall while counter bits 4:3 are both zero.
  // ---------------------------------------------------------------------------
  logic [5:0] stall_phase = '0;
  int         stall_mode  = 0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        result.ready <= 1'b1;
      end
      1: begin
        result.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        result.ready <= (stall_phase[2:0] != 3'd5);
      end
      default: begin
        result.ready <= (stall_phase[4:3] != 2'b00);
      end
    endcase
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pop_results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one item and hold it until it is taken.
  // Between bursts, drop valid for a random gap, unless the gap drawn is zero.
  task automatic send_item(input kind_t k, input logic [CHAR_W-1:0] b,
                           input logic [CAP_W-1:0] cap, input pin_t pin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        feed.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0)
      burst_left--;
    pins_waiting.push_back(pin);
    items_sent++;
    if (k == KIND_POP)
      pops_sent++;
    feed.valid      <= 1'b1;
    feed.kind       <= k;
    feed.byte_value <= b;
    feed.capacity   <= cap;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
  endtask

  // On a byte item the capacity field is ignored, so fill it at random
  task automatic send_byte(input logic [CHAR_W-1:0] b);
    send_item(KIND_BYTE, b, CAP_W'($urandom_range(0, 127)), NO_PIN);
  endtask

  // On a pop the byte field is ignored, so fill it at random
  task automatic send_pop(input logic [CAP_W-1:0] cap, input pin_t pin);
    send_item(KIND_POP, CHAR_W'($urandom_range(0, 255)), cap, pin);
  endtask

  // Hold the sender until every expected result has been taken
  task automatic wait_drain();
    feed.valid <= 1'b0;
    @(posedge clk);
    while (pop_results_due.size() != 0 || pins_waiting.size() != 0) @(posedge clk);
  endtask

  function automatic pin_t pin_of(input status_t st, input logic [FLEN_W-1:0] flen,
                                  input logic [DROP_W-1:0] drops);
    pin_t p;
    p = '{1'b1, st, flen, drops};
    return p;
  endfunction

  function automatic dir_row_t text_row(input logic [CHAR_W-1:0] b, input int reps,
                                        input bit nl, input int lines);
    dir_row_t r;
    r       = '0;
    r.kind  = KIND_BYTE;
    r.b     = b;
    r.reps  = reps[6:0];
    r.nl    = nl;
    r.lines = lines[3:0];
    r.pin   = NO_PIN;
    return r;
  endfunction

  function automatic dir_row_t pop_row(input logic [CAP_W-1:0] cap, input int lines,
                                       input pin_t pin);
    dir_row_t r;
    r       = '0;
    r.kind  = KIND_POP;
    r.cap   = cap;
    r.reps  = 7'd1;
    r.lines = lines[3:0];
    r.pin   = pin;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t          plan [$];
    logic [CHAR_W-1:0] c;
    int                len;
    int                sel;
    int                start;

    feed.valid      = 1'b0;
    feed.kind       = KIND_BYTE;
    feed.byte_value = '0;
    feed.capacity   = '0;
    result.ready    = 1'b0;

    // Pop on the empty queue straight after reset
    plan.push_back(pop_row(7'd64, 1, pin_of(ST_EMPTY, 6'd0, 16'd0)));
    // Lone carriage return and an empty line: nothing is committed or counted
    plan.push_back(text_row(CHAR_CR, 1, 1'b0, 1));
    plan.push_back(text_row(CHAR_LF, 1, 1'b0, 1));
    // Four-character frame with byte extremes and a carriage return mid-line
    plan.push_back(text_row(8'h41, 1, 1'b0, 1));
    plan.push_back(text_row(8'hFF, 1, 1'b0, 1));
    plan.push_back(text_row(8'h00, 1, 1'b0, 1));
    plan.push_back(text_row(CHAR_CR, 1, 1'b0, 1));
    plan.push_back(text_row(8'h80, 1, 1'b1, 1));
    // Capacity equal to the length, then zero: too small, and the frame stays queued
    plan.push_back(pop_row(7'd4, 1, pin_of(ST_SMALL, 6'd4, 16'd0)));
    plan.push_back(pop_row(7'd0, 1, pin_of(ST_SMALL, 6'd4, 16'd0)));
    // Capacity above the clamp streams the frame
    plan.push_back(pop_row(7'd127, 1, NO_PIN));
    // Longest legal line: 63 characters
    plan.push_back(text_row(8'h78, 63, 1'b1, 1));
    plan.push_back(pop_row(7'd63, 1, pin_of(ST_SMALL, 6'd63, 16'd0)));
    plan.push_back(pop_row(7'd64, 1, NO_PIN));
    // Overlong line: the 64th byte drops it, the next byte is skipped, and a CR is
    // ignored while discarding. The newline ends the discard.
    plan.push_back(text_row(8'h79, 65, 1'b0, 1));
    plan.push_back(text_row(CHAR_CR, 1, 1'b0, 1));
    plan.push_back(text_row(CHAR_LF, 1, 1'b0, 1));
    plan.push_back(pop_row(7'd1, 1, pin_of(ST_EMPTY, 6'd0, 16'd1)));
    // Fill all usable slots. The eighth line meets a full queue and is dropped.
    plan.push_back(text_row(8'h6B, 1, 1'b1, 7));
    plan.push_back(text_row(8'h71, 1, 1'b1, 1));
    plan.push_back(pop_row(7'd1, 1, pin_of(ST_SMALL, 6'd1, 16'd2)));
    plan.push_back(pop_row(7'd2, 7, NO_PIN));
    plan.push_back(pop_row(7'd127, 1, pin_of(ST_EMPTY, 6'd0, 16'd2)));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int l = 0; l < plan[i].lines; l++) begin
        if (plan[i].kind == KIND_POP) begin
          send_pop(plan[i].cap, plan[i].pin);
        end else begin
          repeat (plan[i].reps) send_byte(plan[i].b);
          if (plan[i].nl)
            send_byte(CHAR_LF);
        end
      end
    end

    // Let the queue run dry before the random part
    wait_drain();

    // Random part: mostly well-formed lines with random text, pops with random or
    // boundary capacities, and some raw noise bytes. Hold now and then until drained.
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        sel = $urandom_range(0, 99);
        len = (sel < 80) ? $urandom_range(1, 12) :
              (sel < 92) ? $urandom_range(13, 63) : $urandom_range(64, 70);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_byte(CHAR_CR);
          do c = CHAR_W'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
          send_byte(c);
        end
        // Leave the odd line open so that it runs on into the next one
        if ($urandom_range(0, 9) != 0)
          send_byte(CHAR_LF);
      end else if (sel < 85) begin
        // Aim at the head frame's length about a third of the time
        if (head_slot != tail_slot && $urandom_range(0, 2) == 0)
          send_pop(ring_len[head_slot] + CAP_W'($urandom_range(0, 1)), NO_PIN);
        else
          send_pop(CAP_W'($urandom_range(0, 127)), NO_PIN);
      end else if (sel < 97) begin
        send_byte(CHAR_W'($urandom_range(0, 255)));
      end else begin
        wait_drain();
      end
    end

    // Drain, then give any stray result time to show
    wait_drain();
    repeat (16) @(posedge clk);

    $display("Ran %0d items (%0d pops), checked %0d results; %0d frames queued, drops %0d",
             items_sent, pops_sent, results_seen, frames_queued, drop_total);
    $display("Covered edge cases, random lines with overflow and full-queue drops, ",
             "and pops streamed into a stalling receiver");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
